// ===== rtl/iopr_pkg.sv =====
// Shared types, command codes and register addresses of the I/O page register unit.
package iopr_pkg;

	typedef enum logic [2:0] {
		CMD_WORD_READ  = 3'd0,
		CMD_WORD_WRITE = 3'd1,
		CMD_BYTE_WRITE = 3'd2,
		CMD_RX_CHAR    = 3'd3,
		CMD_TX_DONE    = 3'd4
	} cmd_t;

	// per-line register operations, at most one per beat
	typedef struct packed {
		logic rx_take;
		logic rx_stat_wr;
		logic tx_stat_wr;
		logic tx_buf_wr;
		logic rx_event;
		logic tx_event;
	} line_ctl_t;

	localparam logic [15:0] ADDR_PSW      = 16'hFFFE;
	localparam logic [15:0] ADDR_PSW_HI   = 16'hFFFF;
	localparam logic [15:0] ADDR_DK_STAT  = 16'hFF00;
	localparam logic [15:0] ADDR_DK_ERR   = 16'hFF02;
	localparam logic [15:0] ADDR_DK_CTL   = 16'hFF04;
	localparam logic [15:0] ADDR_DK_CTL_H = 16'hFF05;
	localparam logic [15:0] ADDR_DK_WC    = 16'hFF06;
	localparam logic [15:0] ADDR_DK_WC_H  = 16'hFF07;
	localparam logic [15:0] ADDR_DK_BA    = 16'hFF08;
	localparam logic [15:0] ADDR_DK_BA_H  = 16'hFF09;
	localparam logic [15:0] ADDR_DK_DA    = 16'hFF0A;
	localparam logic [15:0] ADDR_DK_DA_H  = 16'hFF0B;
	localparam logic [15:0] ADDR_CLK_STAT = 16'hFF66;
	localparam logic [15:0] ADDR_RCSR0    = 16'hFF70;
	localparam logic [15:0] ADDR_RBUF0    = 16'hFF72;
	localparam logic [15:0] ADDR_XCSR0    = 16'hFF74;
	localparam logic [15:0] ADDR_XBUF0    = 16'hFF76;
	localparam logic [15:0] ADDR_RCSR1    = 16'hFD40;
	localparam logic [15:0] ADDR_RBUF1    = 16'hFD42;
	localparam logic [15:0] ADDR_XCSR1    = 16'hFD44;
	localparam logic [15:0] ADDR_XBUF1    = 16'hFD46;
	localparam logic [15:0] ADDR_TS_HI    = 16'hFAB0;
	localparam logic [15:0] ADDR_TS_LO    = 16'hFAB2;
	localparam logic [15:0] ADDR_STK_LIM  = 16'hFFFC;
	localparam logic [15:0] ADDR_HALT     = 16'hFABC;

	localparam logic [15:0] DK_CTL_KEEP_W  = 16'hE0B0;
	localparam logic [15:0] DK_CTL_WR_W    = 16'h1F4F;
	localparam logic [15:0] DK_FUNC_MASK   = 16'h000E;
	localparam logic [15:0] DK_CTL_KEEP_BL = 16'hFFB0;
	localparam logic [15:0] DK_CTL_WR_BL   = 16'h004F;
	localparam logic [15:0] DK_CTL_KEEP_BH = 16'hE0FF;
	localparam logic [15:0] DK_CTL_WR_BH   = 16'h1F00;
	localparam logic [15:0] RX_TAKE_MASK   = 16'hFF7E;
	localparam logic [15:0] HALT_MAGIC     = 16'h1234;
	localparam logic [31:0] TS_FALLBACK    = 32'd1521180293;

	localparam int unsigned LINES = 2;

endpackage

// ===== rtl/minicomputer_io_page_registers_unit.sv =====
// Top level of the I/O page register unit: access decode, register file and result beat.
//
// I/O page register unit. Each beat is one bus access (word read, word
// write, byte write) or one serial line event (character received on a
// line, transmit done on a line), taken when start is high and busy is low.
// busy is always low: a new beat can be taken every clock cycle. The beat is
// held in an input register, decoded by shallow logic against the register
// file, and its result is presented from a result register. The result
// leaves the unit through that register, marked by done for exactly one
// cycle. The receiver cannot stall the unit and must take the result in that
// cycle. Register updates of one beat are visible to the beat right behind
// it. read_data is zero for every beat that is not a word read; tx_char and
// tx_unit are zero unless tx_valid is set. status_word always carries the
// processor status word as it stands after the beat. The disk engine and the
// real-time clock are outside: their current words arrive with every beat.
module minicomputer_io_page_registers_unit #(
	parameter int unsigned STACK_LIMIT_ENABLE = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [15:0] address,
	input  logic [15:0] data,
	input  logic        line_unit,
	input  logic [31:0] rtc_seconds,
	input  logic [15:0] disk_status,
	input  logic [15:0] disk_error,
	output logic        done,
	output logic [15:0] read_data,
	output logic        disk_start,
	output logic        halt_request,
	output logic        tx_valid,
	output logic        tx_unit,
	output logic [7:0]  tx_char,
	output logic [15:0] status_word
);
	import iopr_pkg::*;

	// input stage
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [15:0] addr_s1;
	logic [15:0] data_s1;
	logic        line_s1;
	logic [31:0] rtc_s1;
	logic [15:0] dstat_s1;
	logic [15:0] derr_s1;

	// register file
	logic [15:0] psw_q, psw_d;
	logic [15:0] dk_ctl_q, dk_ctl_d;
	logic [15:0] dk_wc_q, dk_wc_d;
	logic [15:0] dk_ba_q, dk_ba_d;
	logic [15:0] dk_da_q, dk_da_d;
	logic [15:0] clk_stat_q, clk_stat_d;
	logic [31:0] ts_q, ts_d;
	logic [15:0] stk_lim_q, stk_lim_d;

	// serial lines
	line_ctl_t   ln_ctl [LINES];
	line_ctl_t   ln_req [LINES];
	logic [15:0] ln_rcsr [LINES];
	logic [7:0]  ln_rbuf [LINES];
	logic [15:0] ln_xcsr [LINES];

	// result register
	logic        done_q;
	logic [15:0] rd_q, rd_d;
	logic        start_q, start_d;
	logic        halt_q, halt_d;
	logic        txv_q, txv_d;
	logic        txu_q, txu_d;
	logic [7:0]  txc_q, txc_d;
	logic [15:0] psw_out_q;

	logic [15:0] addr_even;
	logic [15:0] lo_byte;
	logic [15:0] hi_byte;
	logic [31:0] ts_pick;
	logic        stk_en;

	assign busy      = 1'b0;
	assign stk_en    = (STACK_LIMIT_ENABLE != 0);
	assign addr_even = {addr_s1[15:1], 1'b0};
	assign lo_byte   = {8'h00, data_s1[7:0]};
	assign hi_byte   = {data_s1[7:0], 8'h00};
	// a clock that reads as all zeros or all ones is not running: latch a fixed stamp
	assign ts_pick   = (rtc_s1 == 32'h0 || rtc_s1 == 32'hFFFF_FFFF) ? TS_FALLBACK : rtc_s1;

	// capture the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1   <= cmd;
			addr_s1  <= address;
			data_s1  <= data;
			line_s1  <= line_unit;
			rtc_s1   <= rtc_seconds;
			dstat_s1 <= disk_status;
			derr_s1  <= disk_error;
		end
	end

	// decode and next-state
	always_comb begin
		psw_d      = psw_q;
		dk_ctl_d   = dk_ctl_q;
		dk_wc_d    = dk_wc_q;
		dk_ba_d    = dk_ba_q;
		dk_da_d    = dk_da_q;
		clk_stat_d = clk_stat_q;
		ts_d       = ts_q;
		stk_lim_d  = stk_lim_q;
		rd_d       = '0;
		start_d    = 1'b0;
		halt_d     = 1'b0;
		txv_d      = 1'b0;
		txu_d      = 1'b0;
		txc_d      = '0;
		for (int i = 0; i < LINES; i++) begin
			ln_req[i] = '0;
		end

		case (cmd_t'(cmd_s1))
			CMD_WORD_READ: begin
				// odd word reads drop the low address bit
				case (addr_even)
					ADDR_PSW:      rd_d = psw_q;
					ADDR_DK_STAT:  rd_d = dstat_s1;
					ADDR_DK_ERR:   rd_d = derr_s1;
					ADDR_DK_CTL:   rd_d = dk_ctl_q;
					ADDR_DK_WC:    rd_d = dk_wc_q;
					ADDR_DK_BA:    rd_d = dk_ba_q;
					ADDR_DK_DA:    rd_d = dk_da_q;
					ADDR_CLK_STAT: rd_d = clk_stat_q;
					ADDR_RCSR0:    rd_d = ln_rcsr[0];
					ADDR_RBUF0: begin
						ln_req[0].rx_take = 1'b1;
						rd_d = ln_rcsr[0][7] ? {8'h00, ln_rbuf[0]} : 16'h0;
					end
					ADDR_XCSR0:    rd_d = ln_xcsr[0];
					ADDR_RCSR1:    rd_d = ln_rcsr[1];
					ADDR_RBUF1: begin
						ln_req[1].rx_take = 1'b1;
						rd_d = ln_rcsr[1][7] ? {8'h00, ln_rbuf[1]} : 16'h0;
					end
					ADDR_XCSR1:    rd_d = ln_xcsr[1];
					ADDR_TS_HI: begin
						ts_d = ts_pick;
						rd_d = ts_pick[31:16];
					end
					ADDR_TS_LO:    rd_d = ts_q[15:0];
					ADDR_STK_LIM:  rd_d = stk_en ? stk_lim_q : 16'h0;
					default:       rd_d = '0;
				endcase
			end
			CMD_WORD_WRITE: begin
				if (!addr_s1[0]) begin
					case (addr_s1)
						ADDR_PSW:      psw_d = data_s1;
						ADDR_DK_CTL: begin
							dk_ctl_d = (dk_ctl_q & DK_CTL_KEEP_W) | (data_s1 & DK_CTL_WR_W);
							start_d  = |(dk_ctl_d & DK_FUNC_MASK);
						end
						ADDR_DK_WC:    dk_wc_d = data_s1;
						ADDR_DK_BA:    dk_ba_d = data_s1;
						ADDR_DK_DA:    dk_da_d = data_s1;
						ADDR_CLK_STAT: clk_stat_d = data_s1;
						ADDR_RCSR0:    ln_req[0].rx_stat_wr = 1'b1;
						ADDR_XCSR0:    ln_req[0].tx_stat_wr = 1'b1;
						ADDR_XBUF0: begin
							ln_req[0].tx_buf_wr = 1'b1;
							txv_d = 1'b1;
							txc_d = data_s1[7:0];
						end
						ADDR_RCSR1:    ln_req[1].rx_stat_wr = 1'b1;
						ADDR_XCSR1:    ln_req[1].tx_stat_wr = 1'b1;
						ADDR_XBUF1: begin
							ln_req[1].tx_buf_wr = 1'b1;
							txv_d = 1'b1;
							txu_d = 1'b1;
							txc_d = data_s1[7:0];
						end
						ADDR_STK_LIM: begin
							if (stk_en) begin
								stk_lim_d = data_s1;
							end
						end
						ADDR_HALT:     halt_d = (data_s1 == HALT_MAGIC);
						default: begin
						end
					endcase
				end
			end
			CMD_BYTE_WRITE: begin
				case (addr_s1)
					ADDR_PSW:      psw_d = (psw_q & 16'hFF00) | lo_byte;
					ADDR_PSW_HI:   psw_d = (psw_q & 16'h00FF) | hi_byte;
					ADDR_DK_CTL: begin
						dk_ctl_d = (dk_ctl_q & DK_CTL_KEEP_BL) | (data_s1 & DK_CTL_WR_BL);
						start_d  = |(dk_ctl_d & DK_FUNC_MASK);
					end
					ADDR_DK_CTL_H: dk_ctl_d = (dk_ctl_q & DK_CTL_KEEP_BH) | (hi_byte & DK_CTL_WR_BH);
					ADDR_DK_WC:    dk_wc_d = (dk_wc_q & 16'hFF00) | lo_byte;
					ADDR_DK_WC_H:  dk_wc_d = (dk_wc_q & 16'h00FF) | hi_byte;
					ADDR_DK_BA:    dk_ba_d = (dk_ba_q & 16'hFF00) | lo_byte;
					ADDR_DK_BA_H:  dk_ba_d = (dk_ba_q & 16'h00FF) | hi_byte;
					ADDR_DK_DA:    dk_da_d = (dk_da_q & 16'hFF00) | lo_byte;
					ADDR_DK_DA_H:  dk_da_d = (dk_da_q & 16'h00FF) | hi_byte;
					// a byte write clears the high half of the clock status
					ADDR_CLK_STAT: clk_stat_d = lo_byte;
					ADDR_RCSR0:    ln_req[0].rx_stat_wr = 1'b1;
					ADDR_XCSR0:    ln_req[0].tx_stat_wr = 1'b1;
					ADDR_XBUF0: begin
						ln_req[0].tx_buf_wr = 1'b1;
						txv_d = 1'b1;
						txc_d = data_s1[7:0];
					end
					ADDR_RCSR1:    ln_req[1].rx_stat_wr = 1'b1;
					ADDR_XCSR1:    ln_req[1].tx_stat_wr = 1'b1;
					ADDR_XBUF1: begin
						ln_req[1].tx_buf_wr = 1'b1;
						txv_d = 1'b1;
						txu_d = 1'b1;
						txc_d = data_s1[7:0];
					end
					// the stack limit takes its byte write into the high half
					ADDR_STK_LIM: begin
						if (stk_en) begin
							stk_lim_d = (stk_lim_q & 16'h00FF) | hi_byte;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_RX_CHAR: begin
				if (line_s1) begin
					ln_req[1].rx_event = 1'b1;
				end else begin
					ln_req[0].rx_event = 1'b1;
				end
			end
			CMD_TX_DONE: begin
				if (line_s1) begin
					ln_req[1].tx_event = 1'b1;
				end else begin
					ln_req[0].tx_event = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// only a live beat may touch the lines
		for (int i = 0; i < LINES; i++) begin
			ln_ctl[i] = valid_s1 ? ln_req[i] : '0;
		end
	end

	for (genvar g = 0; g < LINES; g++) begin : g_line
		iopr_line u_line (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ln_ctl[g]),
			.data      (data_s1),
			.rx_status (ln_rcsr[g]),
			.rx_buffer (ln_rbuf[g]),
			.tx_status (ln_xcsr[g])
		);
	end

	// commit register updates of a live beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psw_q      <= '0;
			dk_ctl_q   <= '0;
			dk_wc_q    <= '0;
			dk_ba_q    <= '0;
			dk_da_q    <= '0;
			clk_stat_q <= '0;
			ts_q       <= '0;
			stk_lim_q  <= '0;
		end else if (valid_s1) begin
			psw_q      <= psw_d;
			dk_ctl_q   <= dk_ctl_d;
			dk_wc_q    <= dk_wc_d;
			dk_ba_q    <= dk_ba_d;
			dk_da_q    <= dk_da_d;
			clk_stat_q <= clk_stat_d;
			ts_q       <= ts_d;
			stk_lim_q  <= stk_lim_d;
		end
	end

	// result beat: one cycle of done per live beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rd_q      <= rd_d;
			start_q   <= start_d;
			halt_q    <= halt_d;
			txv_q     <= txv_d;
			txu_q     <= txu_d;
			txc_q     <= txc_d;
			psw_out_q <= psw_d;
		end
	end

	assign done         = done_q;
	assign read_data    = rd_q;
	assign disk_start   = start_q;
	assign halt_request = halt_q;
	assign tx_valid     = txv_q;
	assign tx_unit      = txu_q;
	assign tx_char      = txc_q;
	assign status_word  = psw_out_q;

`ifndef SYNTHESIS
	// every accepted beat yields a result through the input and result registers
	a_beat_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat produced no result");

	// no result without an earlier accepted beat
	a_result_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted beat");

	// a transmitted character and a read word never share a beat
	a_tx_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && tx_valid) |-> (read_data == 16'h0 && !disk_start && !halt_request))
		else $error("transmit beat carries other results");

	// the transmit line stays zero unless a character went out
	a_tx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tx_valid) |-> (tx_char == 8'h00 && !tx_unit))
		else $error("tx fields set without tx_valid");
`endif

endmodule

// ===== rtl/iopr_line.sv =====
// One serial line: receive status and buffer, transmit status.
module iopr_line (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iopr_pkg::line_ctl_t   ctl,
	input  logic [15:0]           data,
	output logic [15:0]           rx_status,
	output logic [7:0]            rx_buffer,
	output logic [15:0]           tx_status
);
	import iopr_pkg::*;

	logic [15:0] rx_status_q, rx_status_d;
	logic [7:0]  rx_buffer_q, rx_buffer_d;
	logic [15:0] tx_status_q, tx_status_d;

	always_comb begin
		rx_status_d = rx_status_q;
		rx_buffer_d = rx_buffer_q;
		tx_status_d = tx_status_q;
		// a buffer read only consumes the character when one is waiting
		if (ctl.rx_take && rx_status_q[7]) begin
			rx_status_d = rx_status_q & RX_TAKE_MASK;
		end
		if (ctl.rx_stat_wr) begin
			rx_status_d[6] = data[6];
			if (data[0]) begin
				rx_status_d[7] = 1'b0;
			end
		end
		if (ctl.rx_event) begin
			rx_buffer_d    = data[7:0];
			rx_status_d[7] = 1'b1;
		end
		if (ctl.tx_stat_wr) begin
			tx_status_d[6] = data[6];
		end
		if (ctl.tx_buf_wr) begin
			tx_status_d[7] = 1'b0;
		end
		if (ctl.tx_event) begin
			tx_status_d[7] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_status_q <= '0;
			rx_buffer_q <= '0;
			tx_status_q <= '0;
		end else begin
			rx_status_q <= rx_status_d;
			rx_buffer_q <= rx_buffer_d;
			tx_status_q <= tx_status_d;
		end
	end

	assign rx_status = rx_status_q;
	assign rx_buffer = rx_buffer_q;
	assign tx_status = tx_status_q;

endmodule

// ===== sim/minicomputer_io_page_registers_unit_tb.sv =====
// Self-checking bench for the I/O page register unit: scoreboard class, beat drivers, monitor.
`timescale 1ns / 1ps

module minicomputer_io_page_registers_unit_tb;
	import iopr_pkg::*;

	localparam int unsigned STACK_LIMIT_ENABLE = 1;
	// stop issuing new beats once this many have gone in
	localparam int unsigned BEATS_TARGET = 1350;
	// cycles with neither a beat taken nor a result seen before the run is called hung
	localparam int unsigned STALL_LIMIT = 2000;
	// the result trails start by the input and result registers; leave a little margin after the last one
	localparam int unsigned TAIL_CYCLES = 4;

	localparam logic [15:0] ADDR_SWITCHES     = 16'hFF78;
	localparam logic [15:0] RX_DONE           = 16'h0080;
	localparam logic [15:0] TX_READY          = 16'h0080;
	localparam logic [15:0] INT_ENABLE        = 16'h0040;
	localparam logic [15:0] RX_DONE_CLEAR_BIT = 16'h0001;
	localparam logic [31:0] RTC_ALL_ONES      = 32'hFFFF_FFFF;

	// one result beat; field order matches the concatenation of output ports below
	typedef struct packed {
		logic [15:0] read_data;
		logic        disk_start;
		logic        halt_request;
		logic        tx_valid;
		logic        tx_unit;
		logic [7:0]  tx_char;
		logic [15:0] status_word;
	} io_reply_t;

	// Shadow register file of the unit plus the queue of replies it still owes.
	class io_page_scoreboard;
		logic [15:0] psw, dk_ctl, dk_wc, dk_ba, dk_da, clk_stat, stk_lim;
		logic [15:0] rcsr [LINES];
		logic [7:0]  rbuf [LINES];
		logic [15:0] xcsr [LINES];
		logic [7:0]  xbuf [LINES];
		logic [31:0] ts_latch;
		io_reply_t   reply_q[$];
		int unsigned mismatches;

		function new();
			psw = '0; dk_ctl = '0; dk_wc = '0; dk_ba = '0; dk_da = '0;
			clk_stat = '0; stk_lim = '0; ts_latch = '0; mismatches = 0;
			foreach (rcsr[i]) begin
				rcsr[i] = '0; rbuf[i] = '0; xcsr[i] = '0; xbuf[i] = '0;
			end
		endfunction

		function logic [15:0] take_rx(int u);
			if ((rcsr[u] & RX_DONE) == '0)
				return '0;
			rcsr[u] = rcsr[u] & RX_TAKE_MASK;
			return {8'h00, rbuf[u]};
		endfunction

		function void write_csr(int u, bit is_rx, logic [15:0] d);
			logic [15:0] csr;
			csr = is_rx ? rcsr[u] : xcsr[u];
			csr = ((d & INT_ENABLE) != '0) ? (csr | INT_ENABLE) : (csr & ~INT_ENABLE);
			if (is_rx && (d & RX_DONE_CLEAR_BIT) != '0)
				csr = csr & ~RX_DONE;
			if (is_rx)
				rcsr[u] = csr;
			else
				xcsr[u] = csr;
		endfunction

		// serial line registers behave the same for word and byte writes
		function void line_write(logic [15:0] a, logic [15:0] d, inout io_reply_t r);
			int u;
			case (a)
				ADDR_RCSR0: write_csr(0, 1'b1, d);
				ADDR_RCSR1: write_csr(1, 1'b1, d);
				ADDR_XCSR0: write_csr(0, 1'b0, d);
				ADDR_XCSR1: write_csr(1, 1'b0, d);
				ADDR_XBUF0, ADDR_XBUF1: begin
					u = (a == ADDR_XBUF1) ? 1 : 0;
					xbuf[u] = d[7:0];
					xcsr[u] = xcsr[u] & ~TX_READY;
					r.tx_valid = 1'b1;
					r.tx_unit = 1'(u);
					r.tx_char = d[7:0];
				end
				default: ;
			endcase
		endfunction

		function logic [15:0] read_word(logic [15:0] a, logic [31:0] rtc,
				logic [15:0] ds, logic [15:0] de);
			case ({a[15:1], 1'b0})
				ADDR_PSW:      return psw;
				ADDR_DK_STAT:  return ds;
				ADDR_DK_ERR:   return de;
				ADDR_DK_CTL:   return dk_ctl;
				ADDR_DK_WC:    return dk_wc;
				ADDR_DK_BA:    return dk_ba;
				ADDR_DK_DA:    return dk_da;
				ADDR_CLK_STAT: return clk_stat;
				ADDR_RCSR0:    return rcsr[0];
				ADDR_RBUF0:    return take_rx(0);
				ADDR_XCSR0:    return xcsr[0];
				ADDR_RCSR1:    return rcsr[1];
				ADDR_RBUF1:    return take_rx(1);
				ADDR_XCSR1:    return xcsr[1];
				ADDR_TS_HI: begin
					ts_latch = (rtc == '0 || rtc == RTC_ALL_ONES) ? TS_FALLBACK : rtc;
					return ts_latch[31:16];
				end
				ADDR_TS_LO:    return ts_latch[15:0];
				ADDR_STK_LIM:  return (STACK_LIMIT_ENABLE != 0) ? stk_lim : '0;
				default:       return '0;
			endcase
		endfunction

		// Apply one beat to the shadow registers and return the reply it causes.
		function io_reply_t access_registers(logic [2:0] op, logic [15:0] a, logic [15:0] d,
				logic ln, logic [31:0] rtc, logic [15:0] ds, logic [15:0] de);
			io_reply_t r;
			r = '0;
			case (op)
				CMD_WORD_READ: r.read_data = read_word(a, rtc, ds, de);
				CMD_WORD_WRITE: if (!a[0]) begin
					case (a)
						ADDR_PSW: psw = d;
						ADDR_DK_CTL: begin
							dk_ctl = (dk_ctl & DK_CTL_KEEP_W) | (d & DK_CTL_WR_W);
							r.disk_start = (dk_ctl & DK_FUNC_MASK) != '0;
						end
						ADDR_DK_WC:    dk_wc = d;
						ADDR_DK_BA:    dk_ba = d;
						ADDR_DK_DA:    dk_da = d;
						ADDR_CLK_STAT: clk_stat = d;
						ADDR_STK_LIM:  if (STACK_LIMIT_ENABLE != 0) stk_lim = d;
						ADDR_HALT:     r.halt_request = (d == HALT_MAGIC);
						default:       line_write(a, d, r);
					endcase
				end
				CMD_BYTE_WRITE: case (a)
					ADDR_PSW:    psw = {psw[15:8], d[7:0]};
					ADDR_PSW_HI: psw = {d[7:0], psw[7:0]};
					ADDR_DK_CTL: begin
						dk_ctl = (dk_ctl & DK_CTL_KEEP_BL) | (d & DK_CTL_WR_BL);
						r.disk_start = (dk_ctl & DK_FUNC_MASK) != '0;
					end
					ADDR_DK_CTL_H: dk_ctl = (dk_ctl & DK_CTL_KEEP_BH)
						| ({d[7:0], 8'h00} & DK_CTL_WR_BH);
					ADDR_DK_WC:    dk_wc = {dk_wc[15:8], d[7:0]};
					ADDR_DK_WC_H:  dk_wc = {d[7:0], dk_wc[7:0]};
					ADDR_DK_BA:    dk_ba = {dk_ba[15:8], d[7:0]};
					ADDR_DK_BA_H:  dk_ba = {d[7:0], dk_ba[7:0]};
					ADDR_DK_DA:    dk_da = {dk_da[15:8], d[7:0]};
					ADDR_DK_DA_H:  dk_da = {d[7:0], dk_da[7:0]};
					ADDR_CLK_STAT: clk_stat = {8'h00, d[7:0]};
					ADDR_STK_LIM:  if (STACK_LIMIT_ENABLE != 0) stk_lim = {d[7:0], stk_lim[7:0]};
					default:       line_write(a, d, r);
				endcase
				CMD_RX_CHAR: begin
					rbuf[ln] = d[7:0];
					rcsr[ln] = rcsr[ln] | RX_DONE;
				end
				CMD_TX_DONE: xcsr[ln] = xcsr[ln] | TX_READY;
				default: ;
			endcase
			r.status_word = psw;
			return r;
		endfunction

		function void note_access(logic [2:0] op, logic [15:0] a, logic [15:0] d, logic ln,
				logic [31:0] rtc, logic [15:0] ds, logic [15:0] de);
			reply_q.push_back(access_registers(op, a, d, ln, rtc, ds, de));
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(io_reply_t got);
			io_reply_t want;
			if (reply_q.size() == 0) begin
				$display("%0t: result with no beat outstanding: expected none, got %h",
					$time, got);
				mismatches++;
				return;
			end
			want = reply_q.pop_front();
			compare("read_data", 32'(want.read_data), 32'(got.read_data));
			compare("disk_start", 32'(want.disk_start), 32'(got.disk_start));
			compare("halt_request", 32'(want.halt_request), 32'(got.halt_request));
			compare("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
			compare("tx_unit", 32'(want.tx_unit), 32'(got.tx_unit));
			compare("tx_char", 32'(want.tx_char), 32'(got.tx_char));
			compare("status_word", 32'(want.status_word), 32'(got.status_word));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [15:0] address;
	logic [15:0] data;
	logic        line_unit;
	logic [31:0] rtc_seconds;
	logic [15:0] disk_status;
	logic [15:0] disk_error;
	logic        done;
	logic [15:0] read_data;
	logic        disk_start;
	logic        halt_request;
	logic        tx_valid;
	logic        tx_unit;
	logic [7:0]  tx_char;
	logic [15:0] status_word;

	io_reply_t         seen_reply;
	io_page_scoreboard sb;
	int unsigned       quiet_cycles;
	int unsigned       beats_sent;
	int unsigned       burst_left;

	assign seen_reply = {read_data, disk_start, halt_request, tx_valid, tx_unit, tx_char,
		status_word};

	minicomputer_io_page_registers_unit #(
		.STACK_LIMIT_ENABLE(STACK_LIMIT_ENABLE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.address(address),
		.data(data),
		.line_unit(line_unit),
		.rtc_seconds(rtc_seconds),
		.disk_status(disk_status),
		.disk_error(disk_error),
		.done(done),
		.read_data(read_data),
		.disk_start(disk_start),
		.halt_request(halt_request),
		.tx_valid(tx_valid),
		.tx_unit(tx_unit),
		.tx_char(tx_char),
		.status_word(status_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: sample at the rising edge, before the unit's own updates land.
	// Check the result first so a stray strobe cannot pair with the beat taken
	// at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(seen_reply);
			if (start && !busy)
				sb.note_access(cmd, address, data, line_unit, rtc_seconds, disk_status,
					disk_error);
		end
	end

	// Watchdog: any cycle that moves a beat either way resets the count.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("minicomputer_io_page_registers_unit verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one beat and hold it until the unit takes it. Leave start high:
	// the caller either stacks the next beat or drops start.
	task automatic issue(input logic [2:0] op, input logic [15:0] a, input logic [15:0] d,
			input logic ln, input logic [31:0] rtc, input logic [15:0] ds,
			input logic [15:0] de);
		start <= 1'b1;
		cmd <= op;
		address <= a;
		data <= d;
		line_unit <= ln;
		rtc_seconds <= rtc;
		disk_status <= ds;
		disk_error <= de;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Mostly short gaps, now and then a long one or a back-to-back burst.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(input logic [2:0] op, input logic [15:0] a, input logic [15:0] d,
			input logic ln, input logic [31:0] rtc);
		int unsigned gap;
		issue(op, a, d, ln, rtc, 16'($urandom), 16'($urandom));
		beats_sent++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = pick_gap();
			if (gap == 0 && $urandom_range(0, 49) == 0)
				burst_left = $urandom_range(20, 60);
			if (gap != 0)
				idle(gap);
		end
	endtask

	// Drop start and wait until every owed reply has come back, then for TAIL_CYCLES more.
	task automatic hold_until_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (sb.reply_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Mapped registers (odd halves included) most of the time, else any address.
	function automatic logic [15:0] pick_io_addr();
		logic [15:0] a;
		case ($urandom_range(0, 35))
			0:  a = ADDR_PSW;
			1:  a = ADDR_PSW_HI;
			2:  a = ADDR_DK_STAT;
			3:  a = ADDR_DK_ERR;
			4:  a = ADDR_DK_CTL;
			5:  a = ADDR_DK_CTL_H;
			6:  a = ADDR_DK_WC;
			7:  a = ADDR_DK_WC_H;
			8:  a = ADDR_DK_BA;
			9:  a = ADDR_DK_BA_H;
			10: a = ADDR_DK_DA;
			11: a = ADDR_DK_DA_H;
			12: a = ADDR_CLK_STAT;
			13: a = ADDR_RCSR0;
			14: a = ADDR_RBUF0;
			15: a = ADDR_XCSR0;
			16: a = ADDR_XBUF0;
			17: a = ADDR_RCSR1;
			18: a = ADDR_RBUF1;
			19: a = ADDR_XCSR1;
			20: a = ADDR_XBUF1;
			21: a = ADDR_TS_HI;
			22: a = ADDR_TS_LO;
			23: a = ADDR_STK_LIM;
			24: a = ADDR_HALT;
			25: a = ADDR_SWITCHES;
			default: return 16'($urandom);
		endcase
		if ($urandom_range(0, 5) == 0)
			a[0] = 1'b1;
		return a;
	endfunction

	// Favor the halt word and the all-zero / all-one extremes.
	function automatic logic [15:0] pick_data();
		case ($urandom_range(0, 9))
			0:       return HALT_MAGIC;
			1:       return 16'hFFFF;
			2:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Zero and all-ones are the two readings that latch the fallback stamp.
	function automatic logic [31:0] pick_rtc();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return RTC_ALL_ONES;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_cmd();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30) return CMD_WORD_READ;
		if (r < 55) return CMD_WORD_WRITE;
		if (r < 75) return CMD_BYTE_WRITE;
		if (r < 85) return CMD_RX_CHAR;
		if (r < 95) return CMD_TX_DONE;
		// the undecoded codes above transmit done
		return 3'(CMD_TX_DONE) + 3'($urandom_range(1, 3));
	endfunction

	// Directed pass: each register kind, both write widths, the line events and
	// the corner behaviors of the unit.
	task automatic directed_beats();
		send_beat(CMD_WORD_READ, ADDR_PSW, 16'h0000, 1'b0, pick_rtc());
		send_beat(CMD_WORD_WRITE, ADDR_PSW, 16'hFFFF, 1'b0, pick_rtc());
		// byte writes to both halves of the status word
		send_beat(CMD_BYTE_WRITE, ADDR_PSW_HI, 16'h0000, 1'b0, pick_rtc());
		send_beat(CMD_BYTE_WRITE, ADDR_PSW, 16'h1280, 1'b1, pick_rtc());
		// disk control: full word with function bits, then the high byte alone
		send_beat(CMD_WORD_WRITE, ADDR_DK_CTL, 16'hFFFF, 1'b0, pick_rtc());
		send_beat(CMD_BYTE_WRITE, ADDR_DK_CTL_H, 16'h00FF, 1'b0, pick_rtc());
		// odd word read drops the low bit; odd word write is ignored
		send_beat(CMD_WORD_READ, ADDR_DK_CTL_H, 16'h0000, 1'b0, pick_rtc());
		send_beat(CMD_WORD_WRITE, ADDR_DK_WC_H, 16'hFFFF, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_DK_WC, 16'h0000, 1'b0, pick_rtc());
		// receive on line 0, read once with done set and once without
		send_beat(CMD_RX_CHAR, 16'h0000, 16'hFFA5, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_RBUF0, 16'h0000, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_RBUF0, 16'h0000, 1'b0, pick_rtc());
		// line 1: status write sets interrupt enable and clears receive done
		send_beat(CMD_RX_CHAR, 16'hFFFF, 16'h005A, 1'b1, pick_rtc());
		send_beat(CMD_WORD_WRITE, ADDR_RCSR1, 16'h0041, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_RBUF1, 16'h0000, 1'b0, pick_rtc());
		// transmit buffers by word and by byte; buffer read returns zero
		send_beat(CMD_WORD_WRITE, ADDR_XBUF0, 16'hFF5A, 1'b0, pick_rtc());
		send_beat(CMD_BYTE_WRITE, ADDR_XBUF1, 16'h00C3, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_XBUF0, 16'h0000, 1'b0, pick_rtc());
		send_beat(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b1, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_XCSR1, 16'h0000, 1'b0, pick_rtc());
		// timestamp fallback on both degenerate clock readings, then the low half
		send_beat(CMD_WORD_READ, ADDR_TS_HI, 16'h0000, 1'b0, '0);
		send_beat(CMD_WORD_READ, ADDR_TS_HI, 16'h0000, 1'b0, RTC_ALL_ONES);
		send_beat(CMD_WORD_READ, ADDR_TS_LO, 16'h0000, 1'b0, pick_rtc());
		// byte write to the stack limit lands in its high byte
		send_beat(CMD_WORD_WRITE, ADDR_STK_LIM, 16'hFFFF, 1'b0, pick_rtc());
		send_beat(CMD_BYTE_WRITE, ADDR_STK_LIM, 16'h0012, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_STK_LIM, 16'h0000, 1'b0, pick_rtc());
		// byte write to the clock status clears its high byte
		send_beat(CMD_BYTE_WRITE, ADDR_CLK_STAT, 16'hABCD, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, ADDR_CLK_STAT, 16'h0000, 1'b0, pick_rtc());
		send_beat(CMD_WORD_WRITE, ADDR_HALT, HALT_MAGIC, 1'b0, pick_rtc());
		send_beat(CMD_WORD_READ, 16'h0000, 16'h0000, 1'b0, pick_rtc());
		send_beat(3'(CMD_TX_DONE) + 3'd3, 16'hFFFF, 16'hFFFF, 1'b1, RTC_ALL_ONES);
	endtask

	// Random pass: mostly register traffic, with receive, transmit and timestamp
	// sequences woven in so the line state machines get exercised end to end.
	task automatic random_beats();
		int unsigned pick;
		int unsigned next_quiet;
		logic        ln;
		next_quiet = beats_sent + $urandom_range(150, 400);
		while (beats_sent < BEATS_TARGET) begin
			if (beats_sent >= next_quiet) begin
				hold_until_quiet();
				next_quiet = beats_sent + $urandom_range(150, 400);
			end
			pick = $urandom_range(0, 99);
			ln = 1'($urandom_range(0, 1));
			if (pick < 20) begin
				send_beat(CMD_RX_CHAR, pick_io_addr(), pick_data(), ln, pick_rtc());
				if ($urandom_range(0, 3) == 0)
					send_beat(CMD_WORD_WRITE, ln ? ADDR_RCSR1 : ADDR_RCSR0, pick_data(),
						1'($urandom_range(0, 1)), pick_rtc());
				send_beat(CMD_WORD_READ,
					(ln ? ADDR_RBUF1 : ADDR_RBUF0) | 16'($urandom_range(0, 1)),
					pick_data(), 1'($urandom_range(0, 1)), pick_rtc());
			end else if (pick < 30) begin
				send_beat($urandom_range(0, 1) ? CMD_WORD_WRITE : CMD_BYTE_WRITE,
					ln ? ADDR_XBUF1 : ADDR_XBUF0, pick_data(),
					1'($urandom_range(0, 1)), pick_rtc());
				send_beat(CMD_TX_DONE, pick_io_addr(), pick_data(), ln, pick_rtc());
				send_beat(CMD_WORD_READ, ln ? ADDR_XCSR1 : ADDR_XCSR0, pick_data(),
					1'($urandom_range(0, 1)), pick_rtc());
			end else if (pick < 38) begin
				send_beat(CMD_WORD_READ, ADDR_TS_HI, pick_data(), ln, pick_rtc());
				send_beat(CMD_WORD_READ, ADDR_TS_LO, pick_data(), ln, pick_rtc());
			end else begin
				send_beat(pick_cmd(), pick_io_addr(), pick_data(), ln, pick_rtc());
			end
		end
	endtask

	initial begin
		sb = new();
		beats_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_WORD_READ;
		address <= '0;
		data <= '0;
		line_unit <= 1'b0;
		rtc_seconds <= '0;
		disk_status <= '0;
		disk_error <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_beats();
		// drain fully before the random traffic starts
		hold_until_quiet();
		random_beats();
		hold_until_quiet();

		if (sb.mismatches == 0)
			$display("minicomputer_io_page_registers_unit verification clean");
		else
			$display("minicomputer_io_page_registers_unit verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/iopr_pkg.sv
rtl/iopr_line.sv
rtl/minicomputer_io_page_registers_unit.sv
sim/minicomputer_io_page_registers_unit_tb.sv
